>>> design/ppp_lcp_config_request_checker_macros.svh
// Assertion macros used by the checker's top-level RTL file.
`ifndef PPP_LCP_CONFIG_REQUEST_CHECKER_MACROS_SVH
`define PPP_LCP_CONFIG_REQUEST_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PLCRC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define PLCRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/plcrc_pkg.sv
// Types, codes and helpers shared by the LCP configure-request checker.
package plcrc_pkg;

    // Header layout
    localparam logic [15:0] POS_CODE    = 16'd0;
    localparam logic [15:0] POS_IDENT   = 16'd1;
    localparam logic [15:0] POS_LEN_HI  = 16'd2;
    localparam logic [15:0] POS_LEN_LO  = 16'd3;
    localparam logic [15:0] HDR_BYTES   = 16'd4;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;

    // Option sizes
    localparam logic [7:0] MIN_OPT_SIZE   = 8'd2;
    localparam logic [7:0] SHORT_OPT_SIZE = 8'd4;
    localparam logic [7:0] LONG_OPT_SIZE  = 8'd6;

    // Packet codes
    localparam logic [7:0] CODE_CONF_REQ = 8'd1;
    localparam logic [7:0] CODE_CONF_ACK = 8'd2;

    // Option types
    localparam logic [7:0] OPTION_MRU   = 8'd1;
    localparam logic [7:0] OPTION_ACCM  = 8'd2;
    localparam logic [7:0] OPTION_AUTH  = 8'd3;
    localparam logic [7:0] OPTION_QUAL  = 8'd4;
    localparam logic [7:0] OPTION_MAGIC = 8'd5;

    // Verdicts
    localparam logic [2:0] V_DROP  = 3'd0;
    localparam logic [2:0] V_GOOD  = 3'd1;
    localparam logic [2:0] V_NAK   = 3'd2;
    localparam logic [2:0] V_ACK   = 3'd3;
    localparam logic [2:0] V_OTHER = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOCAL_MRU      = 2'd0;
    localparam logic [1:0] CFG_LOCAL_MAGIC    = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_IDENT = 2'd2;

    localparam logic [15:0] MRU_RESET = 16'd1500;

    // One classified beat handed from the front to the back
    typedef struct packed {
        logic        walk;      // byte lies in the option area
        logic        last;      // last byte of the frame
        logic [7:0]  data;
        logic [15:0] room;      // bytes from the byte before this one up to the frame length
        logic [7:0]  code;
        logic        ident_ok;
        logic        len_ok;    // header complete, length sane, frame not truncated
        logic [15:0] plen;
    } t_beat;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // One result
    typedef struct packed {
        logic [2:0]  verdict;
        logic        loop;
        logic [7:0]  code;
        logic [15:0] plen;
    } t_result;

    // Exact size of a known option, zero for an unknown type
    function automatic logic [7:0] required_size(input logic [7:0] opt_type);
        logic [7:0] size;
        case (opt_type)
            OPTION_MRU, OPTION_AUTH, OPTION_QUAL: size = SHORT_OPT_SIZE;
            OPTION_ACCM, OPTION_MAGIC:            size = LONG_OPT_SIZE;
            default:                              size = 8'd0;
        endcase
        return size;
    endfunction

endpackage

>>> design/ppp_lcp_config_request_checker.sv
// Top level of the LCP configure-request checker: registers, front, queue, back.
//
//  channel | direction | handshake                  | beat
//  --------+-----------+----------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_rx_byte, i_frame_end
//  out     | output    | o_out_valid / i_out_ready  | o_verdict, o_loopback_seen,
//          |           |                            | o_packet_code, o_packet_length
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One byte a cycle while the queue is not full; a verdict passes from the queue into the result
// register, which the frame's last beat enters when the back end pops it from the queue.
// While a stalled output holds the result register, a following last beat waits at the queue
// head and the input takes QUEUE_DEPTH - 1 more beats before o_in_ready drops; ready rises
// again the cycle after the output beat is taken. Reset is synchronous; there is no clearing pass.
`include "ppp_lcp_config_request_checker_macros.svh"

module ppp_lcp_config_request_checker #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input bytes
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    // verdicts
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_verdict,
    output logic        o_loopback_seen,
    output logic [7:0]  o_packet_code,
    output logic [15:0] o_packet_length,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [15:0]          r_local_mru;
    logic [31:0]          r_local_magic;
    logic [7:0]           r_expected_ident;
    logic                 w_accept;
    logic                 w_pop;
    plcrc_pkg::t_beat     w_in_beat, w_q_beat;
    plcrc_pkg::t_q_stat   w_q_stat;
    plcrc_pkg::t_result   w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mru      <= plcrc_pkg::MRU_RESET;
            r_local_magic    <= '0;
            r_expected_ident <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                plcrc_pkg::CFG_LOCAL_MRU:      r_local_mru      <= i_cfg_data[15:0];
                plcrc_pkg::CFG_LOCAL_MAGIC:    r_local_magic    <= i_cfg_data;
                plcrc_pkg::CFG_EXPECTED_IDENT: r_expected_ident <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = !w_q_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;

    plcrc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_rx_byte        (i_rx_byte),
        .i_frame_end      (i_frame_end),
        .i_expected_ident (r_expected_ident),
        .o_beat           (w_in_beat)
    );

    plcrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_wdata (w_in_beat),
        .i_pop   (w_pop),
        .o_rdata (w_q_beat),
        .o_stat  (w_q_stat)
    );

    plcrc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (w_q_beat),
        .i_q_stat      (w_q_stat),
        .o_pop         (w_pop),
        .i_local_mru   (r_local_mru),
        .i_local_magic (r_local_magic),
        .o_res_valid   (o_out_valid),
        .i_res_ready   (i_out_ready),
        .o_res         (w_res)
    );

    assign o_verdict       = w_res.verdict;
    assign o_loopback_seen = w_res.loop;
    assign o_packet_code   = w_res.code;
    assign o_packet_length = w_res.plen;

    // Loopback is only reported on an accepted or nak'd request
    `PLCRC_ASSERT_IMPLIES(a_loop_on_request, i_clk, i_rst_n,
        o_out_valid && o_loopback_seen,
        (o_verdict == plcrc_pkg::V_GOOD) || (o_verdict == plcrc_pkg::V_NAK),
        "loopback flag on a verdict other than accept or nak")

    // Any verdict but drop needs a complete header with a sane length
    `PLCRC_ASSERT_IMPLIES(a_kept_has_length, i_clk, i_rst_n,
        o_out_valid && (o_verdict != plcrc_pkg::V_DROP),
        o_packet_length >= plcrc_pkg::HDR_BYTES,
        "frame kept with a length below the header size")

    // A popped last beat always lands in the result register
    `PLCRC_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n,
        w_pop && w_q_beat.last,
        o_out_valid,
        "last beat taken from the queue without a result")

endmodule

>>> design/plcrc_front.sv
// Front end: takes bytes, tracks the header and tags each beat for the back end.
module plcrc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_frame_end,
    input  logic [7:0]            i_expected_ident,
    output plcrc_pkg::t_beat      o_beat
);

    logic [15:0] r_byte_pos, n_byte_pos;
    logic [15:0] r_frame_len, n_frame_len;
    logic [7:0]  r_code, n_code;
    logic        r_ident, n_ident;
    logic [16:0] w_count;

    // Header capture and beat tagging
    always_comb begin
        n_code      = r_code;
        n_ident     = r_ident;
        n_frame_len = r_frame_len;
        case (r_byte_pos)
            plcrc_pkg::POS_CODE:   n_code = i_rx_byte;
            plcrc_pkg::POS_IDENT:  n_ident = (i_rx_byte == i_expected_ident);
            plcrc_pkg::POS_LEN_HI: n_frame_len = {i_rx_byte, 8'h00};
            plcrc_pkg::POS_LEN_LO: n_frame_len = {r_frame_len[15:8], i_rx_byte};
            default: ;
        endcase

        // bytes received including this one
        w_count = {1'b0, r_byte_pos} + 17'd1;

        if (r_byte_pos == plcrc_pkg::POS_MAX) begin
            n_byte_pos = r_byte_pos;
        end else begin
            n_byte_pos = w_count[15:0];
        end

        o_beat.walk     = (r_byte_pos >= plcrc_pkg::HDR_BYTES) && (r_byte_pos < r_frame_len);
        o_beat.last     = i_frame_end;
        o_beat.data     = i_rx_byte;
        o_beat.room     = r_frame_len - r_byte_pos + 16'd1;
        o_beat.code     = n_code;
        o_beat.ident_ok = n_ident;
        o_beat.len_ok   = (w_count >= {1'b0, plcrc_pkg::HDR_BYTES})
                       && (n_frame_len >= plcrc_pkg::HDR_BYTES)
                       && (w_count >= {1'b0, n_frame_len});
        o_beat.plen     = (w_count < {1'b0, plcrc_pkg::HDR_BYTES}) ? 16'd0 : n_frame_len;
    end

    // Frame state, cleared after the last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= '0;
            r_frame_len <= '0;
            r_code      <= '0;
            r_ident     <= 1'b0;
        end else if (i_accept) begin
            if (i_frame_end) begin
                r_byte_pos  <= '0;
                r_frame_len <= '0;
                r_code      <= '0;
                r_ident     <= 1'b0;
            end else begin
                r_byte_pos  <= n_byte_pos;
                r_frame_len <= n_frame_len;
                r_code      <= n_code;
                r_ident     <= n_ident;
            end
        end
    end

endmodule

>>> design/plcrc_queue.sv
// Short beat queue between the front and back ends.
module plcrc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  plcrc_pkg::t_beat      i_wdata,
    input  logic                  i_pop,
    output plcrc_pkg::t_beat      o_rdata,
    output plcrc_pkg::t_q_stat    o_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    plcrc_pkg::t_beat r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_rdata      = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> design/plcrc_back.sv
// Back end: walks the options, forms the verdict and holds the result register.
module plcrc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  plcrc_pkg::t_beat      i_beat,
    input  plcrc_pkg::t_q_stat    i_q_stat,
    output logic                  o_pop,
    input  logic [15:0]           i_local_mru,
    input  logic [31:0]           i_local_magic,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output plcrc_pkg::t_result    o_res
);

    logic [7:0]  r_opt_type, n_opt_type;
    logic [7:0]  r_opt_len, n_opt_len;
    logic [7:0]  r_opt_off, n_opt_off;
    logic [31:0] r_opt_value, n_opt_value;
    logic        r_nak, n_nak;
    logic        r_malf, n_malf;
    logic        r_loop, n_loop;
    logic        r_res_valid, n_res_valid;
    plcrc_pkg::t_result r_res, n_res;
    logic        w_finish;
    logic [7:0]  w_need;

    // A last beat waits for the result register to be free
    assign o_pop = !i_q_stat.empty && (!i_beat.last || !r_res_valid || i_res_ready);
    assign w_need = plcrc_pkg::required_size(r_opt_type);

    always_comb begin
        n_opt_type  = r_opt_type;
        n_opt_len   = r_opt_len;
        n_opt_off   = r_opt_off;
        n_opt_value = r_opt_value;
        n_nak       = r_nak;
        n_malf      = r_malf;
        n_loop      = r_loop;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        w_finish    = 1'b0;

        // Option walk, one byte a beat
        if (o_pop && i_beat.walk && !r_malf) begin
            if (r_opt_off == 8'd0) begin
                n_opt_type  = i_beat.data;
                n_opt_value = '0;
                n_opt_off   = 8'd1;
            end else if (r_opt_off == 8'd1) begin
                n_opt_len = i_beat.data;
                if ((i_beat.data < plcrc_pkg::MIN_OPT_SIZE)
                    || ({8'h00, i_beat.data} > i_beat.room)
                    || ((w_need != 8'd0) && (i_beat.data != w_need))) begin
                    n_malf = 1'b1;
                end else begin
                    w_finish  = (i_beat.data == plcrc_pkg::MIN_OPT_SIZE);
                    n_opt_off = w_finish ? 8'd0 : 8'd2;
                end
            end else begin
                n_opt_value = {r_opt_value[23:0], i_beat.data};
                w_finish    = ((r_opt_off + 8'd1) == r_opt_len);
                n_opt_off   = w_finish ? 8'd0 : r_opt_off + 8'd1;
            end

            // Value checks on a completed option
            if (w_finish) begin
                case (r_opt_type)
                    plcrc_pkg::OPTION_MRU: begin
                        if (n_opt_value > {16'h0000, i_local_mru}) n_nak = 1'b1;
                    end
                    plcrc_pkg::OPTION_ACCM: ;
                    plcrc_pkg::OPTION_AUTH, plcrc_pkg::OPTION_QUAL: begin
                        if (n_opt_value != 32'd0) n_nak = 1'b1;
                    end
                    plcrc_pkg::OPTION_MAGIC: begin
                        if (n_opt_value == i_local_magic) n_loop = 1'b1;
                    end
                    default: n_nak = 1'b1;
                endcase
            end
        end

        // Verdict on the last beat, then clear the frame state
        if (o_pop && i_beat.last) begin
            n_res_valid   = 1'b1;
            n_res.verdict = plcrc_pkg::V_DROP;
            n_res.loop    = 1'b0;
            n_res.code    = i_beat.code;
            n_res.plen    = i_beat.plen;
            if (i_beat.len_ok) begin
                if (i_beat.code == plcrc_pkg::CODE_CONF_REQ) begin
                    if (i_beat.ident_ok && !n_malf && (n_opt_off == 8'd0)) begin
                        n_res.verdict = n_nak ? plcrc_pkg::V_NAK : plcrc_pkg::V_GOOD;
                        n_res.loop    = n_loop;
                    end
                end else if (i_beat.code == plcrc_pkg::CODE_CONF_ACK) begin
                    if (i_beat.ident_ok) n_res.verdict = plcrc_pkg::V_ACK;
                end else begin
                    n_res.verdict = plcrc_pkg::V_OTHER;
                end
            end
            n_opt_type  = '0;
            n_opt_len   = '0;
            n_opt_off   = '0;
            n_opt_value = '0;
            n_nak       = 1'b0;
            n_malf      = 1'b0;
            n_loop      = 1'b0;
        end
    end

    // Walk state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opt_type  <= '0;
            r_opt_len   <= '0;
            r_opt_off   <= '0;
            r_opt_value <= '0;
            r_nak       <= 1'b0;
            r_malf      <= 1'b0;
            r_loop      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_opt_type  <= n_opt_type;
            r_opt_len   <= n_opt_len;
            r_opt_off   <= n_opt_off;
            r_opt_value <= n_opt_value;
            r_nak       <= n_nak;
            r_malf      <= n_malf;
            r_loop      <= n_loop;
            r_res_valid <= n_res_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

>>> sim/ppp_lcp_config_request_checker_test.sv
// Self-checking testbench for the LCP configure-request checker.
`timescale 1ns / 1ps

module ppp_lcp_config_request_checker_test;

    localparam int CYCLE_LIMIT = 3_000_000;

    // Shadow of the checker: parses each accepted byte and queues the verdict it expects
    class t_lcp_verdict_board;
        logic [15:0] mru_lim;
        logic [31:0] magic;
        logic [7:0]  ident;
        // per-frame parse state
        logic [15:0] pos;
        logic [15:0] flen;
        logic [7:0]  code;
        logic [7:0]  otype;
        logic [7:0]  olen;
        logic [7:0]  ooff;
        logic [31:0] oval;
        logic        id_ok;
        logic        nak;
        logic        bad;
        logic        loop;
        plcrc_pkg::t_result verdicts_due[$];
        int          errors;

        function new();
            mru_lim = plcrc_pkg::MRU_RESET;
            magic   = '0;
            ident   = '0;
            errors  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos   = '0;
            flen  = '0;
            code  = '0;
            otype = '0;
            olen  = '0;
            ooff  = '0;
            oval  = '0;
            id_ok = 1'b0;
            nak   = 1'b0;
            bad   = 1'b0;
            loop  = 1'b0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                plcrc_pkg::CFG_LOCAL_MRU:      mru_lim = d[15:0];
                plcrc_pkg::CFG_LOCAL_MAGIC:    magic = d;
                plcrc_pkg::CFG_EXPECTED_IDENT: ident = d[7:0];
                default: ;
            endcase
        endfunction

        // One accepted input beat
        function void take_byte(logic [7:0] b, logic last);
            logic [15:0] p;
            logic [7:0]  need;
            int          n;
            int          room;
            plcrc_pkg::t_result r;
            p = pos;
            if (p == plcrc_pkg::POS_CODE) begin
                code = b;
            end else if (p == plcrc_pkg::POS_IDENT) begin
                id_ok = (b == ident);
            end else if (p == plcrc_pkg::POS_LEN_HI) begin
                flen = {b, 8'h00};
            end else if (p == plcrc_pkg::POS_LEN_LO) begin
                flen[7:0] = b;
            end else if (p < flen && !bad) begin
                // option walk
                if (ooff == 0) begin
                    otype = b;
                    oval  = '0;
                    ooff  = 8'd1;
                end else begin
                    if (ooff == 8'd1) begin
                        case (otype)
                            plcrc_pkg::OPTION_MRU, plcrc_pkg::OPTION_AUTH,
                            plcrc_pkg::OPTION_QUAL:  need = plcrc_pkg::SHORT_OPT_SIZE;
                            plcrc_pkg::OPTION_ACCM,
                            plcrc_pkg::OPTION_MAGIC: need = plcrc_pkg::LONG_OPT_SIZE;
                            default:                 need = '0;
                        endcase
                        olen = b;
                        // room counts from this option's type byte to the length field
                        room = int'(flen) - int'(p) + 1;
                        if (b < plcrc_pkg::MIN_OPT_SIZE || int'(b) > room
                            || (need != 0 && b != need))
                            bad = 1'b1;
                    end else begin
                        oval = {oval[23:0], b};
                    end
                    if (!bad) begin
                        if (int'(ooff) + 1 == int'(olen)) begin
                            case (otype)
                                plcrc_pkg::OPTION_MRU:
                                    if (oval > {16'h0, mru_lim}) nak = 1'b1;
                                plcrc_pkg::OPTION_ACCM: ;
                                plcrc_pkg::OPTION_AUTH, plcrc_pkg::OPTION_QUAL:
                                    if (oval != 0) nak = 1'b1;
                                plcrc_pkg::OPTION_MAGIC:
                                    if (oval == magic) loop = 1'b1;
                                default: nak = 1'b1;
                            endcase
                            ooff = '0;
                        end else begin
                            ooff = ooff + 8'd1;
                        end
                    end
                end
            end
            if (p != plcrc_pkg::POS_MAX) pos = p + 16'd1;
            if (!last) return;

            // frame closes: work out the verdict
            n         = int'(p) + 1;
            r.verdict = plcrc_pkg::V_DROP;
            r.loop    = 1'b0;
            r.code    = code;
            r.plen    = (n < int'(plcrc_pkg::HDR_BYTES)) ? 16'h0 : flen;
            if (n >= int'(plcrc_pkg::HDR_BYTES) && flen >= plcrc_pkg::HDR_BYTES
                && n >= int'(flen)) begin
                if (code == plcrc_pkg::CODE_CONF_REQ) begin
                    if (id_ok && !bad && ooff == 0) begin
                        r.verdict = nak ? plcrc_pkg::V_NAK : plcrc_pkg::V_GOOD;
                        r.loop    = loop;
                    end
                end else if (code == plcrc_pkg::CODE_CONF_ACK) begin
                    if (id_ok) r.verdict = plcrc_pkg::V_ACK;
                end else begin
                    r.verdict = plcrc_pkg::V_OTHER;
                end
            end
            verdicts_due.push_back(r);
            clear_frame();
        endfunction

        // One accepted output beat against the oldest expected verdict
        function void match_verdict(plcrc_pkg::t_result got);
            plcrc_pkg::t_result want;
            if (verdicts_due.size() == 0) begin
                $error("verdict %0d arrived with no frame pending", got.verdict);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.verdict !== want.verdict) begin
                $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                errors++;
            end
            if (got.loop !== want.loop) begin
                $error("loopback_seen: expected %0d, got %0d", want.loop, got.loop);
                errors++;
            end
            if (got.code !== want.code) begin
                $error("packet_code: expected %0h, got %0h", want.code, got.code);
                errors++;
            end
            if (got.plen !== want.plen) begin
                $error("packet_length: expected %0h, got %0h", want.plen, got.plen);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = '0;
    logic        i_frame_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_verdict;
    logic        o_loopback_seen;
    logic [7:0]  o_packet_code;
    logic [15:0] o_packet_length;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = plcrc_pkg::CFG_LOCAL_MRU;
    logic [31:0] i_cfg_data = '0;

    t_lcp_verdict_board board;
    logic [7:0]       pkt[$];
    int               sent = 0;
    int               burst_left = 0;
    bit               pressure_go = 1'b0;
    int               cycles = 0;

    ppp_lcp_config_request_checker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_verdict       (o_verdict),
        .o_loopback_seen (o_loopback_seen),
        .o_packet_code   (o_packet_code),
        .o_packet_length (o_packet_length),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) @(posedge i_clk) cycles++;
        $display("ppp_lcp_config_request_checker verification failed");
        $finish;
    end

    // Output side: stall segments of varying density, one long hold-off for back-pressure
    initial begin : verdict_sink
        int seg_left;
        int ready_pct;
        bit held;
        seg_left  = 0;
        ready_pct = 100;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_go && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 80);
                case ($urandom_range(0, 4))
                    0, 1:    ready_pct = 100;
                    2:       ready_pct = 75;
                    3:       ready_pct = 50;
                    default: ready_pct = 15;
                endcase
            end
            seg_left--;
            i_out_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Output monitor
    initial begin : verdict_monitor
        plcrc_pkg::t_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.verdict = o_verdict;
                got.loop    = o_loopback_seen;
                got.code    = o_packet_code;
                got.plen    = o_packet_length;
                board.match_verdict(got);
            end
        end
    end

    // One input beat, in bursts with idle gaps between them
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_frame_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        board.take_byte(b, last);
        sent++;
    endtask

    task automatic send_pkt();
        foreach (pkt[k]) send_byte(pkt[k], k == pkt.size() - 1);
    endtask

    function automatic void start_pkt(logic [7:0] c, logic [7:0] id, logic [15:0] len);
        pkt = {c, id, len[15:8], len[7:0]};
    endfunction

    // type, length, then length-2 value bytes, big-endian from the low end of v
    function automatic void add_opt(logic [7:0] t, logic [7:0] l, logic [31:0] v);
        pkt.push_back(t);
        pkt.push_back(l);
        for (int k = int'(l) - 3; k >= 0; k--)
            pkt.push_back((k < 4) ? v[8*k +: 8] : 8'($urandom));
    endfunction

    function automatic void fix_len();
        pkt[2] = 8'(pkt.size() >> 8);
        pkt[3] = 8'(pkt.size());
    endfunction

    // Let the pipeline empty before touching the registers
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] mru, logic [31:0] magic, logic [7:0] id);
        logic [31:0] d;
        d = {16'($urandom), mru};
        i_cfg_we    <= 1'b1;
        i_cfg_index <= plcrc_pkg::CFG_LOCAL_MRU;
        i_cfg_data  <= d;
        @(posedge i_clk);
        board.write_reg(plcrc_pkg::CFG_LOCAL_MRU, d);
        i_cfg_index <= plcrc_pkg::CFG_LOCAL_MAGIC;
        i_cfg_data  <= magic;
        @(posedge i_clk);
        board.write_reg(plcrc_pkg::CFG_LOCAL_MAGIC, magic);
        d = {24'($urandom), id};
        i_cfg_index <= plcrc_pkg::CFG_EXPECTED_IDENT;
        i_cfg_data  <= d;
        @(posedge i_clk);
        board.write_reg(plcrc_pkg::CFG_EXPECTED_IDENT, d);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed requests with random options; acks, other codes and noise besides
    task automatic random_frame();
        int         kind;
        int         mut;
        logic [7:0] id;
        logic [7:0] t;
        logic [31:0] v;
        id   = ($urandom_range(0, 9) != 0) ? board.ident : 8'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            start_pkt(plcrc_pkg::CODE_CONF_REQ, id, 16'h0);
            repeat ($urandom_range(0, 5)) begin
                case ($urandom_range(0, 11))
                    0, 1: begin
                        case ($urandom_range(0, 3))
                            0:       v = {16'h0, board.mru_lim};
                            1:       v = {16'h0, 16'(board.mru_lim + 16'd1)};
                            2:       v = $urandom_range(0, 65535);
                            default: v = $urandom_range(0, 1500);
                        endcase
                        add_opt(plcrc_pkg::OPTION_MRU, plcrc_pkg::SHORT_OPT_SIZE, v);
                    end
                    2, 3: add_opt(plcrc_pkg::OPTION_ACCM, plcrc_pkg::LONG_OPT_SIZE, $urandom);
                    4: add_opt(plcrc_pkg::OPTION_AUTH, plcrc_pkg::SHORT_OPT_SIZE,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0);
                    5: add_opt(plcrc_pkg::OPTION_QUAL, plcrc_pkg::SHORT_OPT_SIZE,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0);
                    6, 7: add_opt(plcrc_pkg::OPTION_MAGIC, plcrc_pkg::LONG_OPT_SIZE,
                                  ($urandom_range(0, 4) < 2) ? board.magic : $urandom);
                    8, 9: begin
                        t = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(6, 255));
                        add_opt(t, 8'($urandom_range(2, 7)), $urandom);
                    end
                    10: begin
                        // known option with a random size, often the wrong one
                        t = 8'($urandom_range(1, 5));
                        add_opt(t, 8'($urandom_range(0, 7)), $urandom);
                    end
                    default: pkt.push_back(8'($urandom));   // lone type byte
                endcase
            end
        end else if (kind < 85) begin
            start_pkt((kind < 75) ? plcrc_pkg::CODE_CONF_ACK : 8'($urandom), id, 16'h0);
            repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom));
        end else begin
            pkt = {};
            repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
        end
        if (kind < 85) begin
            fix_len();
            mut = $urandom_range(0, 19);
            if (mut < 2) begin
                repeat ($urandom_range(1, 3)) if (pkt.size() > 1) void'(pkt.pop_back());
            end else if (mut < 5) begin
                repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
            end else if (mut == 5) begin
                pkt[2] = '0;
                pkt[3] = 8'($urandom_range(0, 12));
            end
        end
        send_pkt();
    endtask

    // Stimulus
    initial begin : stimulus
        int target;
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // too short for a header
        pkt = {8'hFF};
        send_pkt();
        pkt = {plcrc_pkg::CODE_CONF_REQ, 8'h00, 8'h00};
        send_pkt();
        // length field below the header size
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'd2);
        send_pkt();
        // length says 10, only 8 bytes arrive
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'd10);
        add_opt(plcrc_pkg::OPTION_MRU, plcrc_pkg::SHORT_OPT_SIZE, 32'd100);
        send_pkt();
        // wrong identifier
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h5A, 16'h0);
        fix_len();
        send_pkt();
        // every known option, all acceptable, MRU right at the limit
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'h0);
        add_opt(plcrc_pkg::OPTION_MRU, plcrc_pkg::SHORT_OPT_SIZE, 32'd1500);
        add_opt(plcrc_pkg::OPTION_ACCM, plcrc_pkg::LONG_OPT_SIZE, 32'hFFFF_FFFF);
        add_opt(plcrc_pkg::OPTION_AUTH, plcrc_pkg::SHORT_OPT_SIZE, 32'h0);
        add_opt(plcrc_pkg::OPTION_QUAL, plcrc_pkg::SHORT_OPT_SIZE, 32'h0);
        add_opt(plcrc_pkg::OPTION_MAGIC, plcrc_pkg::LONG_OPT_SIZE, 32'h1234_5678);
        fix_len();
        send_pkt();
        // nak cases: MRU one over, auth asked, quality asked, unknown type
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'h0);
        add_opt(plcrc_pkg::OPTION_MRU, plcrc_pkg::SHORT_OPT_SIZE, 32'd1501);
        fix_len();
        send_pkt();
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'h0);
        add_opt(plcrc_pkg::OPTION_AUTH, plcrc_pkg::SHORT_OPT_SIZE, 32'hC023);
        fix_len();
        send_pkt();
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'h0);
        add_opt(plcrc_pkg::OPTION_QUAL, plcrc_pkg::SHORT_OPT_SIZE, 32'hC025);
        fix_len();
        send_pkt();
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'h0);
        add_opt(8'hFF, 8'd3, 32'h0);
        fix_len();
        send_pkt();
        // peer magic equal to ours: looped-back link
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'h0);
        add_opt(plcrc_pkg::OPTION_MAGIC, plcrc_pkg::LONG_OPT_SIZE, 32'h0);
        fix_len();
        send_pkt();
        // option length below two; the nak option after it is ignored
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'h0);
        add_opt(8'h00, 8'd1, 32'h0);
        add_opt(plcrc_pkg::OPTION_MRU, plcrc_pkg::SHORT_OPT_SIZE, 32'hFFFF);
        fix_len();
        send_pkt();
        // option running past the length field
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'd9);
        add_opt(8'h40, 8'd9, 32'hFFFF_FFFF);
        send_pkt();
        // known option of the wrong size
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'h0);
        add_opt(plcrc_pkg::OPTION_MRU, 8'd5, 32'h0);
        fix_len();
        send_pkt();
        // lone type byte at the end
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'h0);
        add_opt(plcrc_pkg::OPTION_ACCM, plcrc_pkg::LONG_OPT_SIZE, 32'h0);
        pkt.push_back(plcrc_pkg::OPTION_MAGIC);
        fix_len();
        send_pkt();
        // matching ack with bytes past the length field
        start_pkt(plcrc_pkg::CODE_CONF_ACK, 8'h00, 16'h0);
        fix_len();
        pkt.push_back(8'hAA);
        pkt.push_back(8'h55);
        send_pkt();
        // ack with the wrong identifier
        start_pkt(plcrc_pkg::CODE_CONF_ACK, 8'h01, 16'h0);
        fix_len();
        send_pkt();
        // other codes
        start_pkt(8'h09, 8'h33, 16'h0);
        pkt.push_back(8'h00);
        pkt.push_back(8'hFF);
        fix_len();
        send_pkt();
        start_pkt(8'h00, 8'h00, 16'h0);
        fix_len();
        send_pkt();
        // empty request
        start_pkt(plcrc_pkg::CODE_CONF_REQ, 8'h00, 16'h0);
        fix_len();
        send_pkt();
        drain();

        // random traffic over several register settings, extremes included
        pressure_go = 1'b1;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       set_config(16'h0000, 32'hFFFF_FFFF, 8'hFF);
                1:       set_config(16'hFFFF, 32'h0, 8'h00);
                2:       set_config(16'($urandom), $urandom, 8'($urandom));
                3:       set_config(plcrc_pkg::MRU_RESET, $urandom, 8'($urandom));
                default: set_config(16'($urandom_range(0, 3000)), $urandom, 8'h01);
            endcase
            target = sent + 200;
            while (sent < target) random_frame();
            drain();
        end

        if (board.errors == 0) begin
            $display("ppp_lcp_config_request_checker verification clean");
        end else begin
            $display("ppp_lcp_config_request_checker verification failed");
        end
        $finish;
    end

endmodule
